>>> src/sag_pkg.sv
`timescale 1ns / 1ps
package sag_pkg;

  localparam int NODES          = 64;
  localparam int NODE_W         = 6;
  localparam int MAX_ITERATIONS = 255;
  localparam int W_ADDR_W       = 2 * NODE_W;
  localparam int ACT_W          = 16;
  localparam int NX_W           = 24;
  localparam int TOT_W          = 22;
  localparam int PROD_W         = 32;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SET    = 4'd1,
    OP_RMNODE = 4'd2,
    OP_RMEDGE = 4'd3,
    OP_INJECT = 4'd4,
    OP_SPREAD = 4'd5,
    OP_DECAY  = 4'd6,
    OP_NORM   = 4'd7,
    OP_RDACT  = 4'd8,
    OP_RDWT   = 4'd9,
    OP_CLEAR  = 4'd10
  } op_e;

  localparam logic [1:0] CFG_MAX  = 2'd0;
  localparam logic [1:0] CFG_THR  = 2'd1;
  localparam logic [1:0] CFG_RATE = 2'd2;

  localparam logic [15:0] MAX_RESET  = 16'd32768;
  localparam logic [15:0] THR_RESET  = 16'd3277;
  localparam logic [15:0] RATE_RESET = 16'd32768;

  typedef enum logic [5:0] {
    S_INIT, S_IDLE, S_DSP, S_SE2, S_RMN, S_CLR, S_INJ, S_RDC,
    S_CP0, S_CP1, S_SRC0, S_SRC1, S_SUM0, S_SUM1, S_GV0, S_GV1, S_GV2,
    S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_WB0, S_WB1,
    S_DC0, S_DC1, S_DC2, S_NM0, S_NM1, S_NN0, S_NN1, S_NN2, S_NN3, S_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]         iterations;
    logic [15:0]        decay_factor;
    logic [15:0]        edge_weight;
    logic signed [16:0] amount;
    logic [5:0]         target_node;
    logic [5:0]         node;
    logic [3:0]         op;
  } in_item_t;

  typedef struct packed {
    logic        present;
    logic [15:0] weight_value;
    logic [15:0] activation_value;
  } res_t;

  typedef struct packed {
    logic [15:0] max_activation;
    logic [15:0] activation_threshold;
    logic [15:0] spreading_rate;
  } cfg_t;

endpackage

>>> src/sag_div.sv
`timescale 1ns / 1ps
module sag_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sag_pkg::PROD_W-1:0] dividend,
  input  logic [sag_pkg::TOT_W-1:0]  divisor,
  output logic                      done,
  output logic [15:0]               quotient
);

  logic [sag_pkg::TOT_W-1:0]  rem;
  logic [sag_pkg::PROD_W-1:0] quo;
  logic [sag_pkg::TOT_W-1:0]  dvs;
  logic [4:0]                 cnt;
  logic                       busy;
  logic [sag_pkg::TOT_W:0]    sh;
  logic                       ge;
  logic [sag_pkg::TOT_W:0]    diff;

  assign sh       = {rem, quo[sag_pkg::PROD_W-1]};
  assign ge       = sh >= {1'b0, dvs};
  assign diff     = sh - {1'b0, dvs};
  assign quotient = quo[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[sag_pkg::TOT_W-1:0] : sh[sag_pkg::TOT_W-1:0];
      quo <= {quo[sag_pkg::PROD_W-2:0], ge};
    end
  end

endmodule

>>> src/sag_seq.sv
`timescale 1ns / 1ps
module sag_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sag_pkg::in_item_t item,
  input  sag_pkg::cfg_t     cfg,
  input  logic              out_free,
  output logic              ready,
  output logic              res_valid,
  output sag_pkg::res_t     res
);

  sag_pkg::state_e state, state_next;

  logic [sag_pkg::NODES-1:0] pres, pres_next;
  logic [sag_pkg::NODE_W-1:0] ci, ci_next, cj, cj_next;
  logic [6:0]  ck, ck_next;
  logic [11:0] cc, cc_next;
  logic [7:0]  it_r, it_next;

  logic [3:0]               op_r, op_next;
  logic [5:0]               n_r, n_next, t_r, t_next;
  logic signed [16:0]       amt_r, amt_next;
  logic [15:0]              wt_r, wt_next, fac_r, fac_next;
  logic [15:0]              a_r, a_next, give_r, give_next, w_r, w_next, m_r, m_next;
  logic [sag_pkg::TOT_W-1:0] tot_r, tot_next;
  sag_pkg::res_t            res_r, res_next;

  logic [15:0] act_mem [sag_pkg::NODES];
  logic [23:0] nx_mem [sag_pkg::NODES];
  logic [15:0] w_mem [2**sag_pkg::W_ADDR_W];

  logic [15:0] act_q, w_q;
  logic [23:0] nx_q;
  logic        act_we, nx_we, w_we;
  logic [5:0]  act_wa, act_ra, nx_wa, nx_ra;
  logic [15:0] act_wd, w_wd;
  logic [23:0] nx_wd;
  logic [11:0] w_wa, w_ra;

  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic        div_start, div_done;
  logic [15:0] div_q;
  logic [sag_pkg::TOT_W-1:0] div_dvs;

  logic               m_upd;
  logic signed [18:0] inj_sum;
  logic [16:0]        dec_v;
  logic [15:0]        dec_sat;

  assign m_upd   = pres[cj] && (act_q > m_r);
  assign inj_sum = $signed({3'b000, (pres[n_r] ? act_q : 16'd0)})
                 + {{2{amt_r[16]}}, amt_r};
  assign dec_v   = prod[31:15];
  assign dec_sat = dec_v[16] ? 16'hFFFF : dec_v[15:0];
  assign div_dvs = (state == sag_pkg::S_D3) ? tot_r : {6'd0, m_r};

  assign ready     = (state == sag_pkg::S_IDLE);
  assign res_valid = (state == sag_pkg::S_DONE) && out_free;
  assign res       = res_r;

  sag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_wa] <= act_wd;
    end
    act_q <= act_mem[act_ra];
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    nx_q <= nx_mem[nx_ra];
    if (w_we) begin
      w_mem[w_wa] <= w_wd;
    end
    w_q <= w_mem[w_ra];
  end

  always_comb begin
    state_next = state;
    case (state)
      sag_pkg::S_INIT: begin
        if (cc == 12'hFFF) state_next = sag_pkg::S_IDLE;
      end
      sag_pkg::S_IDLE: begin
        if (start) state_next = sag_pkg::S_DSP;
      end
      sag_pkg::S_DSP: begin
        case (op_r)
          sag_pkg::OP_SET:    state_next = sag_pkg::S_SE2;
          sag_pkg::OP_RMNODE: state_next = pres[n_r] ? sag_pkg::S_RMN : sag_pkg::S_DONE;
          sag_pkg::OP_INJECT: state_next = sag_pkg::S_INJ;
          sag_pkg::OP_SPREAD: state_next = (it_r == 8'd0) ? sag_pkg::S_DONE : sag_pkg::S_CP0;
          sag_pkg::OP_DECAY:  state_next = sag_pkg::S_DC0;
          sag_pkg::OP_NORM:   state_next = sag_pkg::S_NM0;
          sag_pkg::OP_RDACT,
          sag_pkg::OP_RDWT:   state_next = sag_pkg::S_RDC;
          sag_pkg::OP_CLEAR:  state_next = sag_pkg::S_CLR;
          default:            state_next = sag_pkg::S_DONE;
        endcase
      end
      sag_pkg::S_SE2, sag_pkg::S_INJ, sag_pkg::S_RDC: state_next = sag_pkg::S_DONE;
      sag_pkg::S_RMN: begin
        if (ck == 7'd127) state_next = sag_pkg::S_DONE;
      end
      sag_pkg::S_CLR: begin
        if (cc == 12'hFFF) state_next = sag_pkg::S_DONE;
      end
      sag_pkg::S_CP0: state_next = sag_pkg::S_CP1;
      sag_pkg::S_CP1: state_next = (cj == 6'd63) ? sag_pkg::S_SRC0 : sag_pkg::S_CP0;
      sag_pkg::S_SRC0: state_next = sag_pkg::S_SRC1;
      sag_pkg::S_SRC1: begin
        if (pres[ci] && act_q > cfg.activation_threshold) state_next = sag_pkg::S_SUM0;
        else state_next = (ci == 6'd63) ? sag_pkg::S_WB0 : sag_pkg::S_SRC0;
      end
      sag_pkg::S_SUM0: state_next = sag_pkg::S_SUM1;
      sag_pkg::S_SUM1: state_next = (cj == 6'd63) ? sag_pkg::S_GV0 : sag_pkg::S_SUM0;
      sag_pkg::S_GV0: begin
        if (tot_r != '0) state_next = sag_pkg::S_GV1;
        else state_next = (ci == 6'd63) ? sag_pkg::S_WB0 : sag_pkg::S_SRC0;
      end
      sag_pkg::S_GV1: state_next = sag_pkg::S_GV2;
      sag_pkg::S_GV2: state_next = sag_pkg::S_D0;
      sag_pkg::S_D0:  state_next = sag_pkg::S_D1;
      sag_pkg::S_D1: begin
        if (w_q != 16'd0) state_next = sag_pkg::S_D2;
        else if (cj != 6'd63) state_next = sag_pkg::S_D0;
        else state_next = (ci == 6'd63) ? sag_pkg::S_WB0 : sag_pkg::S_SRC0;
      end
      sag_pkg::S_D2: state_next = sag_pkg::S_D3;
      sag_pkg::S_D3: state_next = sag_pkg::S_D4;
      sag_pkg::S_D4: begin
        if (div_done) state_next = sag_pkg::S_D5;
      end
      sag_pkg::S_D5: begin
        if (cj != 6'd63) state_next = sag_pkg::S_D0;
        else state_next = (ci == 6'd63) ? sag_pkg::S_WB0 : sag_pkg::S_SRC0;
      end
      sag_pkg::S_WB0: state_next = sag_pkg::S_WB1;
      sag_pkg::S_WB1: begin
        if (cj != 6'd63) state_next = sag_pkg::S_WB0;
        else state_next = (it_r == 8'd1) ? sag_pkg::S_DONE : sag_pkg::S_CP0;
      end
      sag_pkg::S_DC0: state_next = sag_pkg::S_DC1;
      sag_pkg::S_DC1: state_next = sag_pkg::S_DC2;
      sag_pkg::S_DC2: state_next = (cj == 6'd63) ? sag_pkg::S_DONE : sag_pkg::S_DC0;
      sag_pkg::S_NM0: state_next = sag_pkg::S_NM1;
      sag_pkg::S_NM1: begin
        if (cj == 6'd63) begin
          state_next = (m_r == 16'd0 && !m_upd) ? sag_pkg::S_DONE : sag_pkg::S_NN0;
        end else begin
          state_next = sag_pkg::S_NM0;
        end
      end
      sag_pkg::S_NN0: state_next = sag_pkg::S_NN1;
      sag_pkg::S_NN1: begin
        if (pres[cj]) state_next = sag_pkg::S_NN2;
        else state_next = (cj == 6'd63) ? sag_pkg::S_DONE : sag_pkg::S_NN0;
      end
      sag_pkg::S_NN2: state_next = sag_pkg::S_NN3;
      sag_pkg::S_NN3: begin
        if (div_done) state_next = (cj == 6'd63) ? sag_pkg::S_DONE : sag_pkg::S_NN0;
      end
      sag_pkg::S_DONE: begin
        if (out_free) state_next = sag_pkg::S_IDLE;
      end
      default: state_next = sag_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pres_next = pres;
    ci_next   = ci;
    cj_next   = cj;
    ck_next   = ck;
    cc_next   = cc;
    it_next   = it_r;
    op_next   = op_r;
    n_next    = n_r;
    t_next    = t_r;
    amt_next  = amt_r;
    wt_next   = wt_r;
    fac_next  = fac_r;
    a_next    = a_r;
    give_next = give_r;
    w_next    = w_r;
    m_next    = m_r;
    tot_next  = tot_r;
    res_next  = res_r;
    act_we    = 1'b0;
    act_wa    = n_r;
    act_wd    = 16'd0;
    act_ra    = n_r;
    nx_we     = 1'b0;
    nx_wa     = cj;
    nx_wd     = 24'd0;
    nx_ra     = ci;
    w_we      = 1'b0;
    w_wa      = {n_r, t_r};
    w_wd      = 16'd0;
    w_ra      = {n_r, t_r};
    mul_a     = act_q;
    mul_b     = cfg.max_activation;
    div_start = 1'b0;
    case (state)
      sag_pkg::S_INIT, sag_pkg::S_CLR: begin
        w_we    = 1'b1;
        w_wa    = cc;
        cc_next = cc + 12'd1;
      end
      sag_pkg::S_IDLE: begin
        if (start) begin
          op_next  = item.op;
          n_next   = item.node;
          t_next   = item.target_node;
          amt_next = item.amount;
          wt_next  = item.edge_weight;
          fac_next = item.decay_factor;
          it_next  = item.iterations;
          res_next = '0;
          ci_next  = '0;
          cj_next  = '0;
          ck_next  = '0;
          cc_next  = '0;
          m_next   = '0;
        end
      end
      sag_pkg::S_DSP: begin
        case (op_r)
          sag_pkg::OP_ADD: begin
            if (!pres[n_r]) begin
              pres_next[n_r] = 1'b1;
              act_we = 1'b1;
              if (amt_r < 0) act_wd = 16'd0;
              else if (amt_r[15:0] > cfg.max_activation) act_wd = cfg.max_activation;
              else act_wd = amt_r[15:0];
            end
          end
          sag_pkg::OP_SET: begin
            w_we = 1'b1;
            w_wd = wt_r;
            if (!pres[n_r]) begin
              pres_next[n_r] = 1'b1;
              act_we = 1'b1;
            end
          end
          sag_pkg::OP_RMNODE: pres_next[n_r] = 1'b0;
          sag_pkg::OP_RMEDGE: w_we = 1'b1;
          sag_pkg::OP_CLEAR:  pres_next = '0;
          default: ;
        endcase
      end
      sag_pkg::S_SE2: begin
        if (!pres[t_r]) begin
          pres_next[t_r] = 1'b1;
          act_we = 1'b1;
          act_wa = t_r;
        end
      end
      sag_pkg::S_RMN: begin
        w_we    = 1'b1;
        w_wa    = ck[6] ? {ck[5:0], n_r} : {n_r, ck[5:0]};
        ck_next = ck + 7'd1;
      end
      sag_pkg::S_INJ: begin
        pres_next[n_r] = 1'b1;
        act_we = 1'b1;
        if (inj_sum < 0) act_wd = 16'd0;
        else if (inj_sum > $signed({3'b000, cfg.max_activation})) act_wd = cfg.max_activation;
        else act_wd = inj_sum[15:0];
      end
      sag_pkg::S_RDC: begin
        res_next.present = pres[n_r];
        if (op_r == sag_pkg::OP_RDACT) res_next.activation_value = pres[n_r] ? act_q : 16'd0;
        else res_next.weight_value = w_q;
      end
      sag_pkg::S_CP0: act_ra = cj;
      sag_pkg::S_CP1: begin
        nx_we   = 1'b1;
        nx_wa   = cj;
        nx_wd   = {8'd0, act_q};
        cj_next = cj + 6'd1;
        ci_next = '0;
      end
      sag_pkg::S_SRC0: act_ra = ci;
      sag_pkg::S_SRC1: begin
        a_next   = act_q;
        tot_next = '0;
        cj_next  = '0;
        if (!(pres[ci] && act_q > cfg.activation_threshold)) ci_next = ci + 6'd1;
      end
      sag_pkg::S_SUM0: w_ra = {ci, cj};
      sag_pkg::S_SUM1: begin
        tot_next = tot_r + {6'd0, w_q};
        cj_next  = cj + 6'd1;
      end
      sag_pkg::S_GV0: begin
        mul_a = a_r;
        mul_b = cfg.spreading_rate;
        if (tot_r == '0) ci_next = ci + 6'd1;
      end
      sag_pkg::S_GV1: begin
        give_next = prod[31:16];
        nx_ra     = ci;
      end
      sag_pkg::S_GV2: begin
        nx_we = 1'b1;
        nx_wa = ci;
        nx_wd = nx_q - {8'd0, give_r};
      end
      sag_pkg::S_D0: w_ra = {ci, cj};
      sag_pkg::S_D1: begin
        w_next = w_q;
        if (w_q == 16'd0) begin
          cj_next = cj + 6'd1;
          if (cj == 6'd63) ci_next = ci + 6'd1;
        end
      end
      sag_pkg::S_D2: begin
        mul_a = give_r;
        mul_b = w_r;
      end
      sag_pkg::S_D3: div_start = 1'b1;
      sag_pkg::S_D4: nx_ra = cj;
      sag_pkg::S_D5: begin
        nx_we   = 1'b1;
        nx_wa   = cj;
        nx_wd   = nx_q + {8'd0, div_q};
        cj_next = cj + 6'd1;
        if (cj == 6'd63) ci_next = ci + 6'd1;
      end
      sag_pkg::S_WB0: nx_ra = cj;
      sag_pkg::S_WB1: begin
        act_wa = cj;
        act_we = pres[cj];
        act_wd = (nx_q > {8'd0, cfg.max_activation}) ? cfg.max_activation : nx_q[15:0];
        cj_next = cj + 6'd1;
        if (cj == 6'd63) it_next = it_r - 8'd1;
      end
      sag_pkg::S_DC0: act_ra = cj;
      sag_pkg::S_DC1: begin
        mul_a = act_q;
        mul_b = fac_r;
      end
      sag_pkg::S_DC2: begin
        act_wa  = cj;
        act_we  = pres[cj];
        act_wd  = (dec_sat < cfg.activation_threshold) ? 16'd0 : dec_sat;
        cj_next = cj + 6'd1;
      end
      sag_pkg::S_NM0: act_ra = cj;
      sag_pkg::S_NM1: begin
        if (m_upd) m_next = act_q;
        cj_next = cj + 6'd1;
      end
      sag_pkg::S_NN0: act_ra = cj;
      sag_pkg::S_NN1: begin
        if (!pres[cj]) cj_next = cj + 6'd1;
      end
      sag_pkg::S_NN2: div_start = 1'b1;
      sag_pkg::S_NN3: begin
        if (div_done) begin
          act_we  = 1'b1;
          act_wa  = cj;
          act_wd  = div_q;
          cj_next = cj + 6'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sag_pkg::S_INIT;
      pres  <= '0;
      cc    <= '0;
    end else begin
      state <= state_next;
      pres  <= pres_next;
      cc    <= cc_next;
    end
  end

  always_ff @(posedge clk) begin
    ci     <= ci_next;
    cj     <= cj_next;
    ck     <= ck_next;
    it_r   <= it_next;
    op_r   <= op_next;
    n_r    <= n_next;
    t_r    <= t_next;
    amt_r  <= amt_next;
    wt_r   <= wt_next;
    fac_r  <= fac_next;
    a_r    <= a_next;
    give_r <= give_next;
    w_r    <= w_next;
    m_r    <= m_next;
    tot_r  <= tot_next;
    res_r  <= res_next;
    prod   <= mul_a * mul_b;
  end

endmodule

>>> src/spreading_activation_graph_unit.sv
`timescale 1ns / 1ps
// Spreading-activation graph engine for 64 nodes with Q1.15 activations and a 64 by 64
// matrix of Q8.8 edge weights, one operation per input beat and one result beat per
// operation. After reset the block sweeps the 4096-entry weight memory before it
// accepts its first beat; a clear operation runs the same sweep. Remove node clears
// the node's row and column of weights, decay walks all 64 nodes, and normalize finds
// the maximum over all nodes and, when it is nonzero, divides once for each present node.
// Each spread iteration walks every node above threshold, sums its outgoing weights
// and, when that node has outgoing weight, runs the 32-step shared divider for each
// nonzero edge leaving it; a spread repeats the iteration for the iteration count. All
// multiplies and divides go through one 16 by 16 multiplier and one divider under the
// sequencer.
module spreading_activation_graph_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op, node, target_node, amount, edge_weight, decay_factor, iterations
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // activation_value, weight_value, present
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  sag_pkg::cfg_t  cfg;
  sag_pkg::res_t  res;
  logic           res_valid;
  logic           seq_ready;
  logic           out_free;

  assign s_tready = seq_ready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_activation       <= sag_pkg::MAX_RESET;
      cfg.activation_threshold <= sag_pkg::THR_RESET;
      cfg.spreading_rate       <= sag_pkg::RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        sag_pkg::CFG_MAX:  cfg.max_activation       <= cfg_wdata;
        sag_pkg::CFG_THR:  cfg.activation_threshold <= cfg_wdata;
        sag_pkg::CFG_RATE: cfg.spreading_rate       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {7'd0, res};
    end
  end

  sag_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid && seq_ready),
    .item      (sag_pkg::in_item_t'(s_tdata[72:0])),
    .cfg       (cfg),
    .out_free  (out_free),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

>>> src/sag_chk.sv
`timescale 1ns / 1ps
module sag_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while an operation is running");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared in the cycle after the input beat");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
    else $error("nonzero value reported for an absent node");

endmodule

bind spreading_activation_graph_unit sag_chk u_sag_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> dv/spreading_activation_graph_checker.sv
`timescale 1ns / 1ps
module spreading_activation_graph_checker
  import sag_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  logic [15:0] act_mem [NODES];
  logic        pres_mem [NODES];
  logic [15:0] wt_mem [NODES * NODES];
  longint      acc_mem [NODES];
  logic [15:0] max_act, thresh, rate;
  res_t        graph_results_q [$];

  assign pending = graph_results_q.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] clamp_act(input longint v);
    if (v < 0) return 16'd0;
    if (v > max_act) return max_act;
    return v[15:0];
  endfunction

  task automatic mark_present(input int n);
    if (!pres_mem[n]) begin
      pres_mem[n] = 1'b1;
      act_mem[n] = 16'd0;
    end
  endtask

  task automatic spread_pass();
    longint total, give;
    for (int i = 0; i < NODES; i++) acc_mem[i] = act_mem[i];
    for (int i = 0; i < NODES; i++) begin
      if (!pres_mem[i] || act_mem[i] <= thresh) continue;
      total = 0;
      for (int j = 0; j < NODES; j++) total += wt_mem[i * NODES + j];
      if (total == 0) continue;
      give = (longint'(act_mem[i]) * rate) >> 16;
      acc_mem[i] -= give;
      for (int j = 0; j < NODES; j++)
        if (wt_mem[i * NODES + j] != 0)
          acc_mem[j] += (give * wt_mem[i * NODES + j]) / total;
    end
    for (int i = 0; i < NODES; i++)
      if (pres_mem[i])
        act_mem[i] = (acc_mem[i] > max_act) ? max_act : acc_mem[i][15:0];
  endtask

  task automatic apply_op(input in_item_t it, output res_t r);
    int n, t;
    longint v, m;
    n = it.node;
    t = it.target_node;
    r = '0;
    case (it.op)
      OP_ADD: begin
        if (!pres_mem[n]) begin
          pres_mem[n] = 1'b1;
          act_mem[n] = clamp_act(longint'(it.amount));
        end
      end
      OP_SET: begin
        mark_present(n);
        mark_present(t);
        wt_mem[n * NODES + t] = it.edge_weight;
      end
      OP_RMNODE: begin
        if (pres_mem[n]) begin
          pres_mem[n] = 1'b0;
          act_mem[n] = 16'd0;
          for (int i = 0; i < NODES; i++) begin
            wt_mem[n * NODES + i] = 16'd0;
            wt_mem[i * NODES + n] = 16'd0;
          end
        end
      end
      OP_RMEDGE: wt_mem[n * NODES + t] = 16'd0;
      OP_INJECT: begin
        mark_present(n);
        act_mem[n] = clamp_act(longint'(act_mem[n]) + longint'(it.amount));
      end
      OP_SPREAD: begin
        for (int k = 0; k < it.iterations; k++) spread_pass();
      end
      OP_DECAY: begin
        for (int i = 0; i < NODES; i++)
          if (pres_mem[i]) begin
            v = (longint'(act_mem[i]) * it.decay_factor) >> 15;
            if (v > 65535) v = 65535;
            if (v < thresh) v = 0;
            act_mem[i] = v[15:0];
          end
      end
      OP_NORM: begin
        m = 0;
        for (int i = 0; i < NODES; i++)
          if (pres_mem[i] && act_mem[i] > m) m = act_mem[i];
        if (m > 0)
          for (int i = 0; i < NODES; i++)
            if (pres_mem[i]) begin
              v = (longint'(act_mem[i]) * max_act) / m;
              act_mem[i] = v[15:0];
            end
      end
      OP_RDACT: begin
        if (pres_mem[n]) begin
          r.activation_value = act_mem[n];
          r.present = 1'b1;
        end
      end
      OP_RDWT: begin
        r.weight_value = wt_mem[n * NODES + t];
        r.present = pres_mem[n];
      end
      OP_CLEAR: begin
        for (int i = 0; i < NODES; i++) begin
          act_mem[i] = 16'd0;
          pres_mem[i] = 1'b0;
        end
        for (int i = 0; i < NODES * NODES; i++) wt_mem[i] = 16'd0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t want, got;
    if (rst) begin
      max_act = MAX_RESET;
      thresh  = THR_RESET;
      rate    = RATE_RESET;
      for (int i = 0; i < NODES; i++) begin
        act_mem[i] = 16'd0;
        pres_mem[i] = 1'b0;
      end
      for (int i = 0; i < NODES * NODES; i++) wt_mem[i] = 16'd0;
      graph_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MAX:  max_act = cfg_wdata;
          CFG_THR:  thresh  = cfg_wdata;
          CFG_RATE: rate    = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        apply_op(in_item_t'(s_tdata[72:0]), want);
        graph_results_q = {graph_results_q, want};
      end
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[32:0]);
        if (graph_results_q.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 0);
        end else begin
          want = graph_results_q.pop_front();
          if (got.activation_value !== want.activation_value)
            report_mismatch("activation_value", got.activation_value, want.activation_value);
          if (got.weight_value !== want.weight_value)
            report_mismatch("weight_value", got.weight_value, want.weight_value);
          if (got.present !== want.present)
            report_mismatch("present", got.present, want.present);
        end
      end
    end
  end

  initial errors = 0;

endmodule

>>> dv/spreading_activation_graph_unit_test.sv
`timescale 1ns / 1ps
module spreading_activation_graph_unit_test;
  import sag_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  int          errors;
  int          pending;
  int          gap_pct;
  int          stall_pct;
  longint      cycles = 0;

  always #10 clk = ~clk;

  spreading_activation_graph_unit u_dut (.*);

  spreading_activation_graph_checker u_checker (.*);

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("spreading_activation_graph_unit_test: errors");
      $finish;
    end
  end

  task automatic send_op(input op_e op, input int n, input int t, input int amt,
                         input int w, input int f, input int it);
    in_item_t item;
    bit ok;
    item.op = op;
    item.node = n[5:0];
    item.target_node = t[5:0];
    item.amount = amt[16:0];
    item.edge_weight = w[15:0];
    item.decay_factor = f[15:0];
    item.iterations = it[7:0];
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= 80'(item);
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic send_random();
    int sel, n, t, amt;
    sel = $urandom_range(0, 99);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    t = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    amt = $urandom();
    if (sel < 12)
      send_op(OP_ADD, n, t, amt, $urandom(), $urandom(), $urandom());
    else if (sel < 28)
      send_op(OP_SET, n, t, amt, ($urandom_range(0, 7) == 0) ? 0 : $urandom(),
              $urandom(), $urandom());
    else if (sel < 31)
      send_op(OP_RMNODE, n, t, amt, $urandom(), $urandom(), $urandom());
    else if (sel < 35)
      send_op(OP_RMEDGE, n, t, amt, $urandom(), $urandom(), $urandom());
    else if (sel < 47)
      send_op(OP_INJECT, n, t, amt, $urandom(), $urandom(), $urandom());
    else if (sel < 57)
      send_op(OP_SPREAD, n, t, amt, $urandom(), $urandom(), $urandom_range(0, 3));
    else if (sel < 61)
      send_op(OP_DECAY, n, t, amt, $urandom(),
              ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32768),
              $urandom());
    else if (sel < 65)
      send_op(OP_NORM, n, t, amt, $urandom(), $urandom(), $urandom());
    else if (sel < 82)
      send_op(OP_RDACT, n, t, amt, $urandom(), $urandom(), $urandom());
    else if (sel < 96)
      send_op(OP_RDWT, n, t, amt, $urandom(), $urandom(), $urandom());
    else if (sel < 97)
      send_op(OP_CLEAR, n, t, amt, $urandom(), $urandom(), $urandom());
    else
      send_op(op_e'($urandom_range(11, 15)), n, t, amt, $urandom(), $urandom(), $urandom());
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] mx, input logic [15:0] thr,
                              input logic [15:0] rt);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_MAX;
    cfg_wdata <= mx;
    @(posedge clk);
    cfg_addr <= CFG_THR;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_addr <= CFG_RATE;
    cfg_wdata <= rt;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_MAX;
    cfg_wdata <= '0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_op(OP_ADD, 0, 0, 65535, 0, 0, 0);
    send_op(OP_ADD, 1, 0, -65535, 0, 0, 0);
    send_op(OP_ADD, 0, 0, 100, 0, 0, 0);
    send_op(OP_INJECT, 1, 0, 20000, 0, 0, 0);
    send_op(OP_SET, 0, 1, 0, 65535, 0, 0);
    send_op(OP_SET, 2, 3, 0, 1, 0, 0);
    send_op(OP_SET, 1, 1, 0, 256, 0, 0);
    send_op(OP_RDWT, 0, 1, 0, 0, 0, 0);
    send_op(OP_RDWT, 63, 63, 0, 0, 0, 0);
    send_op(OP_SPREAD, 0, 0, 0, 0, 0, 1);
    send_op(OP_RDACT, 1, 0, 0, 0, 0, 0);
    send_op(OP_SPREAD, 0, 0, 0, 0, 0, 255);
    send_op(OP_RDACT, 0, 0, 0, 0, 0, 0);
    send_op(OP_DECAY, 0, 0, 0, 0, 65535, 0);
    send_op(OP_DECAY, 0, 0, 0, 0, 32768, 0);
    send_op(OP_NORM, 0, 0, 0, 0, 0, 0);
    send_op(OP_RDACT, 1, 0, 0, 0, 0, 0);
    send_op(OP_RMEDGE, 0, 1, 0, 0, 0, 0);
    send_op(OP_RMEDGE, 5, 6, 0, 0, 0, 0);
    send_op(OP_RMNODE, 1, 0, 0, 0, 0, 0);
    send_op(OP_RMNODE, 40, 0, 0, 0, 0, 0);
    send_op(OP_RDWT, 1, 1, 0, 0, 0, 0);
    send_op(OP_SET, 2, 3, 0, 0, 0, 0);
    send_op(op_e'(4'd15), 63, 63, -1, 65535, 65535, 255);
    send_op(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_op(OP_NORM, 0, 0, 0, 0, 0, 0);
    send_op(OP_INJECT, 63, 0, -1, 0, 0, 0);
    send_op(OP_RDACT, 63, 0, 0, 0, 0, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_config(16'hFFFF, 16'h0000, 16'hFFFF);
        1: write_config(16'h4000, 16'hFFFF, 16'h0000);
        2: write_config($urandom(), $urandom_range(0, 8000), $urandom());
        default: write_config(16'h0000, 16'h0100, 16'h8000);
      endcase
      gap_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 45 : 33) : 0;
      stall_pct = (phase == 2) ? 45 : ((phase == 3) ? 33 : 0);
      for (int k = 0; k < 18; k++) send_random();
      drain();
    end
    write_config(MAX_RESET, THR_RESET, RATE_RESET);
    gap_pct = 33;
    stall_pct = 33;
    for (int k = 0; k < 10; k++) send_random();
    drain();

    if (errors == 0)
      $display("spreading_activation_graph_unit_test: clean");
    else
      $display("spreading_activation_graph_unit_test: errors");
    $finish;
  end

endmodule

>>> files.f
src/sag_pkg.sv
src/sag_div.sv
src/sag_seq.sv
src/spreading_activation_graph_unit.sv
src/sag_chk.sv
dv/spreading_activation_graph_checker.sv
dv/spreading_activation_graph_unit_test.sv
